// ===== src/kvfc_pkg.sv =====
// Package of the key-value request frame checker: widths, codes and item types.
// Depends on nothing; every other file of the block but kvfc_in_if imports it.
package kvfc_pkg;

    // Width of the length accumulator and of the body counters.
    localparam int LENGTH_WIDTH = 24;
    // Fixed width of the length fields in a result item.
    localparam int FIELD_W = 24;
    // Width of the length product before saturation (times ten needs four more bits).
    localparam int PROD_W = LENGTH_WIDTH + 4;

    localparam logic [LENGTH_WIDTH-1:0] LEN_MAX = '1;

    typedef enum logic [3:0] {
        PH_CMD  = 4'b0001,
        PH_LEN  = 4'b0010,
        PH_BODY = 4'b0100,
        PH_HALT = 4'b1000
    } t_phase;

    localparam logic [1:0] ROLE_HDR   = 2'd0;
    localparam logic [1:0] ROLE_KEY   = 2'd1;
    localparam logic [1:0] ROLE_VALUE = 2'd2;
    localparam logic [1:0] ROLE_NL    = 2'd3;

    localparam logic [1:0] KIND_GET = 2'd0;
    localparam logic [1:0] KIND_SET = 2'd1;
    localparam logic [1:0] KIND_DEL = 2'd2;

    localparam logic [2:0] EV_NONE  = 3'd0;
    localparam logic [2:0] EV_OK    = 3'd1;
    localparam logic [2:0] EV_BAD   = 3'd2;
    localparam logic [2:0] EV_LEN   = 3'd3;
    localparam logic [2:0] EV_CLOSE = 3'd4;

    localparam logic [23:0] WORD_GET = 24'h474554;
    localparam logic [23:0] WORD_SET = 24'h534554;
    localparam logic [23:0] WORD_DEL = 24'h44454C;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_DIG0  = 8'h30;
    localparam logic [7:0] CH_DIG9  = 8'h39;

    localparam logic [2:0] CMD_LEN  = 3'd3;
    localparam logic [2:0] CMD_SAT  = 3'd4;
    localparam logic [1:0] NL_SAT   = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       connection_start;
    } t_in_item;

    typedef struct packed {
        logic [7:0]         byte_out;
        logic [1:0]         byte_role;
        logic [1:0]         request_kind;
        logic [2:0]         frame_event;
        logic [FIELD_W-1:0] key_length;
        logic [FIELD_W-1:0] value_length;
    } t_out_item;

endpackage

// ===== src/kvfc_in_if.sv =====
// Input channel of the frame checker: one received byte per item.
// Depends on no other file.
interface kvfc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       connection_start;

    modport source (output valid, output data_byte, output connection_start, input ready);
    modport sink (input valid, input data_byte, input connection_start, output ready);
endinterface

// ===== src/kvfc_out_if.sv =====
// Result channel of the frame checker: one checked byte with its role and event per item.
// Depends on kvfc_pkg for the length field width.
interface kvfc_out_if;
    import kvfc_pkg::*;

    logic               valid;
    logic               ready;
    logic [7:0]         byte_out;
    logic [1:0]         byte_role;
    logic [1:0]         request_kind;
    logic [2:0]         frame_event;
    logic [FIELD_W-1:0] key_length;
    logic [FIELD_W-1:0] value_length;

    modport source (output valid, output byte_out, output byte_role, output request_kind,
                    output frame_event, output key_length, output value_length, input ready);
    modport sink (input valid, input byte_out, input byte_role, input request_kind,
                  input frame_event, input key_length, input value_length, output ready);
endinterface

// ===== src/kvfc_parser.sv =====
// Parser state and per-byte decision logic of the frame checker.
// Depends on kvfc_pkg; the state advances on every cycle that i_step is high.
module kvfc_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  kvfc_pkg::t_in_item  i_item,
    output kvfc_pkg::t_out_item o_result
);
    import kvfc_pkg::*;

    t_phase                  r_phase, n_phase, c_phase;
    logic [23:0]             r_chars, n_chars, c_chars;
    logic [2:0]              r_count, n_count, c_count;
    logic [LENGTH_WIDTH-1:0] r_len, n_len, c_len;
    logic [LENGTH_WIDTH-1:0] r_pos, n_pos, c_pos;
    logic [1:0]              r_nlc, n_nlc, c_nlc;
    logic [LENGTH_WIDTH-1:0] r_first, n_first, c_first;
    logic                    r_null, n_null, c_null;

    logic [7:0]              b;
    logic                    is_nl;
    logic                    cmd_valid;
    logic [1:0]              cmd_kind;
    logic [PROD_W-1:0]       prod;
    logic [LENGTH_WIDTH:0]   pos_inc;
    logic                    last;
    logic [LENGTH_WIDTH-1:0] vlen;

    assign b     = i_item.data_byte;
    assign is_nl = (b == CH_NL);

    always_comb begin
        // A connection start clears all state before the byte is looked at.
        if (i_item.connection_start) begin
            c_phase = PH_CMD;
            c_chars = '0;
            c_count = '0;
            c_len   = '0;
            c_pos   = '0;
            c_nlc   = '0;
            c_first = '0;
            c_null  = 1'b0;
        end else begin
            c_phase = r_phase;
            c_chars = r_chars;
            c_count = r_count;
            c_len   = r_len;
            c_pos   = r_pos;
            c_nlc   = r_nlc;
            c_first = r_first;
            c_null  = r_null;
        end
    end

    always_comb begin
        cmd_valid = 1'b0;
        cmd_kind  = KIND_GET;
        if (c_count == CMD_LEN) begin
            if (c_chars == WORD_GET) begin
                cmd_valid = 1'b1;
                cmd_kind  = KIND_GET;
            end else if (c_chars == WORD_SET) begin
                cmd_valid = 1'b1;
                cmd_kind  = KIND_SET;
            end else if (c_chars == WORD_DEL) begin
                cmd_valid = 1'b1;
                cmd_kind  = KIND_DEL;
            end
        end
    end

    // Length accumulator step: len * 10 + digit, as two shifts and two adds.
    assign prod = (PROD_W'(c_len) << 3) + (PROD_W'(c_len) << 1)
                + PROD_W'(4'(b - CH_DIG0));
    assign pos_inc = {1'b0, c_pos} + (LENGTH_WIDTH+1)'(1);
    assign last    = (pos_inc >= {1'b0, c_len});

    always_comb begin
        n_phase = c_phase;
        n_chars = c_chars;
        n_count = c_count;
        n_len   = c_len;
        n_pos   = c_pos;
        n_nlc   = c_nlc;
        n_first = c_first;
        n_null  = c_null;
        vlen    = '0;

        o_result.byte_out     = b;
        o_result.byte_role    = ROLE_HDR;
        o_result.request_kind = KIND_GET;
        o_result.frame_event  = EV_NONE;
        o_result.key_length   = '0;
        o_result.value_length = '0;

        case (c_phase)
            PH_CMD: begin
                if (b == CH_NUL) begin
                    o_result.frame_event = EV_BAD;
                    n_phase = PH_HALT;
                end else if (is_nl) begin
                    if (cmd_valid) begin
                        o_result.request_kind = cmd_kind;
                        n_phase = PH_LEN;
                    end else begin
                        o_result.frame_event = EV_BAD;
                        n_phase = PH_HALT;
                    end
                end else begin
                    if (c_count < CMD_LEN) begin
                        n_chars = {c_chars[15:0], b};
                    end
                    if (c_count < CMD_SAT) begin
                        n_count = c_count + 3'd1;
                    end
                end
            end
            PH_LEN: begin
                o_result.request_kind = cmd_kind;
                if (is_nl) begin
                    if (c_len == '0) begin
                        o_result.frame_event = EV_CLOSE;
                        n_phase = PH_HALT;
                    end else begin
                        n_phase = PH_BODY;
                    end
                end else if (b < CH_DIG0 || b > CH_DIG9) begin
                    o_result.frame_event = EV_BAD;
                    n_phase = PH_HALT;
                end else if (prod > PROD_W'(LEN_MAX)) begin
                    n_len = LEN_MAX;
                end else begin
                    n_len = prod[LENGTH_WIDTH-1:0];
                end
            end
            PH_BODY: begin
                o_result.request_kind = cmd_kind;
                if (is_nl) begin
                    o_result.byte_role = ROLE_NL;
                    if (c_nlc == 2'd0) begin
                        n_first = c_pos;
                    end
                    if (c_nlc < NL_SAT) begin
                        n_nlc = c_nlc + 2'd1;
                    end
                end else if (c_nlc == 2'd0) begin
                    o_result.byte_role = ROLE_KEY;
                end else begin
                    o_result.byte_role = ROLE_VALUE;
                end
                if (b == CH_NUL) begin
                    n_null = 1'b1;
                end
                // The position never passes the length, so the carry bit is always clear.
                n_pos = pos_inc[LENGTH_WIDTH-1:0];
                vlen  = c_len - n_first - LENGTH_WIDTH'(2);

                if (is_nl && n_nlc == NL_SAT && !last) begin
                    o_result.frame_event = EV_LEN;
                    n_phase = PH_HALT;
                end else if (last) begin
                    if (!is_nl) begin
                        o_result.frame_event = EV_LEN;
                        n_phase = PH_HALT;
                    end else if (n_null) begin
                        o_result.frame_event = EV_BAD;
                        n_phase = PH_HALT;
                    end else if (cmd_kind != KIND_SET && n_nlc > 2'd1) begin
                        o_result.frame_event = EV_BAD;
                        n_phase = PH_HALT;
                    end else if (cmd_kind == KIND_SET && n_first == c_pos) begin
                        o_result.frame_event = EV_BAD;
                        n_phase = PH_HALT;
                    end else begin
                        o_result.frame_event = EV_OK;
                        o_result.key_length  = FIELD_W'(32'(n_first));
                        if (cmd_kind == KIND_SET) begin
                            o_result.value_length = FIELD_W'(32'(vlen));
                        end
                        n_phase = PH_CMD;
                        n_chars = '0;
                        n_count = '0;
                        n_len   = '0;
                        n_pos   = '0;
                        n_nlc   = '0;
                        n_first = '0;
                        n_null  = 1'b0;
                    end
                end
            end
            default: begin
                // Halted: the byte passes with the header role and no event.
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_CMD;
            r_chars <= '0;
            r_count <= '0;
            r_len   <= '0;
            r_pos   <= '0;
            r_nlc   <= '0;
            r_first <= '0;
            r_null  <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_chars <= n_chars;
            r_count <= n_count;
            r_len   <= n_len;
            r_pos   <= n_pos;
            r_nlc   <= n_nlc;
            r_first <= n_first;
            r_null  <= n_null;
        end
    end

`ifndef SYNTHESIS
    a_ok_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_result.frame_event == EV_OK |=> r_phase == PH_CMD)
        else $error("ok event did not return the parser to the command phase");

    a_error_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && (o_result.frame_event == EV_BAD || o_result.frame_event == EV_LEN
                   || o_result.frame_event == EV_CLOSE) |=> r_phase == PH_HALT)
        else $error("error or close event did not halt the parser");

    a_role_in_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.byte_role != ROLE_HDR |-> c_phase == PH_BODY)
        else $error("body role given outside the body phase");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= r_len)
        else $error("body position passed the body length");

    a_value_set_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.value_length != '0 |-> o_result.frame_event == EV_OK
                                         && o_result.request_kind == KIND_SET)
        else $error("value length given without an ok event for SET");
`endif

endmodule

// ===== src/kv_request_frame_checker_unit.sv =====
// Key-value request frame checker, top level: input register, parser, result register.
// Path: an accepted item is held in the input register, its result in the result register.
// Throughput: one item per cycle unless the sink stalls; input register refills as it drains.
// Reset: synchronous, active low; clears both valid flags and the parser to the command phase.
// Depends on kvfc_pkg, kvfc_in_if, kvfc_out_if and kvfc_parser.
module kv_request_frame_checker_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    kvfc_in_if.sink         i_req,
    kvfc_out_if.source      o_res
);
    import kvfc_pkg::*;

    // Input stage: holds one received byte until the parser can take it.
    logic      r_in_valid;
    t_in_item  r_in_item;
    // Result stage: holds the finished result item until the sink takes it.
    logic      r_out_valid;
    t_out_item r_out_item;

    t_out_item step_result;
    logic      out_free;
    logic      step;

    // The result register is free when it is empty or is being emptied this cycle.
    assign out_free = !r_out_valid || o_res.ready;
    // The parser handles the held byte exactly when its result can move on.
    assign step     = r_in_valid && out_free;
    // A new byte enters when the input register is empty or is handing its byte on.
    assign i_req.ready = !r_in_valid || step;

    kvfc_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_in_item),
        .o_result (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_req.valid && i_req.ready) begin
                r_in_valid <= 1'b1;
            end else if (step) begin
                r_in_valid <= 1'b0;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset; the valid flags qualify them.
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in_item.data_byte        <= i_req.data_byte;
            r_in_item.connection_start <= i_req.connection_start;
        end
        if (step) begin
            r_out_item <= step_result;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.byte_out     = r_out_item.byte_out;
    assign o_res.byte_role    = r_out_item.byte_role;
    assign o_res.request_kind = r_out_item.request_kind;
    assign o_res.frame_event  = r_out_item.frame_event;
    assign o_res.key_length   = r_out_item.key_length;
    assign o_res.value_length = r_out_item.value_length;

endmodule
